// ===== design/dfv_pkg.sv =====
`default_nettype none
package dfv_pkg;

  // Sequencer states, one-hot
  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_LSQ   = 11'b000_0000_0010,
    ST_LSQRT = 11'b000_0000_0100,
    ST_LDIV  = 11'b000_0000_1000,
    ST_LWR   = 11'b000_0001_0000,
    ST_PRD   = 11'b000_0010_0000,
    ST_PMUL  = 11'b000_0100_0000,
    ST_PANG  = 11'b000_1000_0000,
    ST_PCOR  = 11'b001_0000_0000,
    ST_PMC   = 11'b010_0000_0000,
    ST_PDONE = 11'b100_0000_0000
  } dfv_state_t;

  // Operation codes on the input tuser
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_PREDICT = 1'b1;

  // One source table entry
  typedef struct packed {
    logic [31:0] dir_l;
    logic [31:0] dir_m;
    logic [31:0] n_minus_one;
    logic [31:0] weight;
    logic        beyond_horizon;
    logic        weight_clipped;
  } dfv_entry_t;

  localparam int ENTRY_W      = $bits(dfv_entry_t);
  localparam int CORDIC_STEPS = 24;
  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [49:0] ACC_MAX = 50'sd140737488355327;
  localparam logic signed [49:0] ACC_MIN = -50'sd140737488355328;

  // atan(2^-i) in 2^-32 turns
  localparam logic [31:0] ATAN_TURNS [0:CORDIC_STEPS-1] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

endpackage
`default_nettype wire

// ===== design/dfv_ram.sv =====
`default_nettype none
module dfv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // Write one word, read one word registered
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== design/direct_fourier_visibility_predict_top.sv =====
`default_nettype none
// Direct Fourier visibility predictor over a table of point sources.
// Input stream: in_tuser selects the operation (0 load a source, 1 predict).
//   A load computes n-1 and weight = flux/n and writes table entry
//   source_index; an index at or above MAX_SOURCES is dropped. A load
//   squares l and m, then runs 32 square-root steps, 63 divide steps and
//   one write, all on one shared multiplier and iterative units.
// A predict sums weight*exp(-2*pi*i*phase) over the first sources_in_use
//   entries and gives one result on the output stream. Each source goes
//   through a table read, three phase products, angle, 24 CORDIC steps and
//   two weight products; a source beyond the horizon stops after its table
//   read. Count 0 gives a zero result with no table read.
// in_tready is high only while the sequencer is idle. A finished result
//   waits in the output register; a stalled receiver holds the next predict
//   in its last step until the register empties. Loads run on regardless.
// The user must write sources_in_use (cfg_wr_en) only while idle; unenforced.
// Reset clears the sequencer, the output valid and sources_in_use; the
//   table keeps whatever it held and must be loaded before it is summed.
module direct_fourier_visibility_predict_top #(
  parameter int MAX_SOURCES = 1024,
  parameter int TRIG_BITS   = 18
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_wr_en,
  input  wire logic [10:0]  cfg_wr_data,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // source_index[9:0], dir_l[41:10], dir_m[73:42], flux[105:74],
  // coord_u[137:106], coord_v[169:138], coord_w[201:170], zero fill
  input  wire logic [207:0] in_tdata,
  // operation[0]
  input  wire logic         in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // sum_real[47:0], sum_imag[95:48], horizon_hit[96], saturated[97], zero fill
  output logic [103:0]      out_tdata
);

  localparam int AW = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
  localparam int CW = $clog2(MAX_SOURCES + 1);

  dfv_pkg::dfv_state_t state_r, state_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [10:0] cfg_r, cfg_nxt;
  logic [31:0] a_r, a_nxt, b_r, b_nxt, c_r, c_nxt, flux_r, flux_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] count_r, count_nxt, k_r, k_nxt;
  logic [63:0] s_r, s_nxt, root_r, root_nxt, bit_r, bit_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [62:0] quo_r, quo_nxt, dvd_r, dvd_nxt;
  logic [42:0] ph_r, ph_nxt;
  logic signed [33:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic flip_r, flip_nxt;
  logic signed [47:0] re_r, re_nxt, im_r, im_nxt;
  logic hz_r, hz_nxt, sat_r, sat_nxt;
  logic [97:0] out_data_r, out_data_nxt;
  logic out_valid_r, out_valid_nxt;
  logic signed [67:0] mul_p_r;
  logic signed [33:0] mul_a, mul_b;

  logic wr_en;
  dfv_pkg::dfv_entry_t wr_entry, rd_entry;
  logic [AW-1:0] wr_addr;

  dfv_ram #(
    .WIDTH (dfv_pkg::ENTRY_W),
    .DEPTH (MAX_SOURCES),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_addr (k_r[AW-1:0]),
    .rd_data (rd_entry)
  );

  // Clamp a 48-bit accumulator plus a term; top bit flags saturation
  function automatic logic [48:0] sat_add(input logic signed [47:0] acc,
                                          input logic signed [37:0] term);
    logic signed [49:0] sum;
    sum = 50'(acc) + 50'(term);
    if (sum > dfv_pkg::ACC_MAX) begin
      sat_add = {1'b1, dfv_pkg::ACC_MAX[47:0]};
    end else if (sum < dfv_pkg::ACC_MIN) begin
      sat_add = {1'b1, dfv_pkg::ACC_MIN[47:0]};
    end else begin
      sat_add = {1'b0, sum[47:0]};
    end
  endfunction

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      dfv_pkg::ST_LSQ: begin
        mul_a = 34'($signed(cnt_r[0] ? b_r : a_r));
        mul_b = mul_a;
      end
      dfv_pkg::ST_PMUL: begin
        unique case (cnt_r[1:0])
          2'd0: begin
            mul_a = 34'($signed(a_r));
            mul_b = 34'($signed(rd_entry.dir_l));
          end
          2'd1: begin
            mul_a = 34'($signed(b_r));
            mul_b = 34'($signed(rd_entry.dir_m));
          end
          default: begin
            mul_a = 34'($signed(c_r));
            mul_b = 34'($signed(rd_entry.n_minus_one));
          end
        endcase
      end
      dfv_pkg::ST_PMC: begin
        mul_a = $signed({2'b00, rd_entry.weight});
        mul_b = cnt_r[0] ? (flip_r ? -y_r : y_r) : (flip_r ? -x_r : x_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p_r <= mul_a * mul_b;
  end

  // Sequencer
  logic [63:0] r2_sum, sq_try;
  logic [32:0] div_t;
  logic [42:0] ph_rnd;
  logic [TRIG_BITS-1:0] q_ph;
  logic [31:0] angle;
  logic signed [33:0] sx, sy, atan_v;
  logic signed [37:0] term;
  logic [48:0] acc_res;
  logic last_src;
  logic [CW-1:0] count_in;

  always_comb begin
    r2_sum  = s_r + mul_p_r[63:0];
    sq_try  = root_r + bit_r;
    div_t   = {rem_r[31:0], dvd_r[62]};
    ph_rnd  = ph_r + (43'd1 << (42 - TRIG_BITS));
    q_ph    = ph_rnd[42 -: TRIG_BITS];
    angle   = {q_ph, {(32 - TRIG_BITS){1'b0}}};
    sx      = x_r >>> cnt_r[4:0];
    sy      = y_r >>> cnt_r[4:0];
    atan_v  = $signed({2'b00, dfv_pkg::ATAN_TURNS[cnt_r[4:0]]});
    term    = 38'((mul_p_r + 68'sd536870912) >>> 30);
    acc_res = cnt_r[1] ? sat_add(im_r, -term) : sat_add(re_r, term);
    last_src = (k_r + CW'(1)) == count_r;
    count_in = (32'(cfg_r) > MAX_SOURCES) ? CW'(MAX_SOURCES) : CW'(cfg_r);
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r + 6'd1;
    cfg_nxt   = cfg_wr_en ? cfg_wr_data : cfg_r;
    a_nxt = a_r; b_nxt = b_r; c_nxt = c_r; flux_nxt = flux_r; idx_nxt = idx_r;
    count_nxt = count_r; k_nxt = k_r;
    s_nxt = s_r; root_nxt = root_r; bit_nxt = bit_r;
    rem_nxt = rem_r; quo_nxt = quo_r; dvd_nxt = dvd_r;
    ph_nxt = ph_r; x_nxt = x_r; y_nxt = y_r; z_nxt = z_r; flip_nxt = flip_r;
    re_nxt = re_r; im_nxt = im_r; hz_nxt = hz_r; sat_nxt = sat_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    wr_en    = 1'b0;
    wr_addr  = idx_r;
    wr_entry = '{dir_l: a_r, dir_m: b_r,
                 n_minus_one: root_r[31:0] - 32'h8000_0000,
                 weight: (|quo_r[62:32]) ? 32'hFFFF_FFFF : quo_r[31:0],
                 beyond_horizon: 1'b0, weight_clipped: |quo_r[62:32]};
    in_tready = (state_r == dfv_pkg::ST_IDLE);

    unique case (state_r)
      dfv_pkg::ST_IDLE: begin
        cnt_nxt = '0;
        if (in_tvalid) begin
          if (in_tuser == dfv_pkg::OP_LOAD) begin
            a_nxt    = in_tdata[41:10];
            b_nxt    = in_tdata[73:42];
            flux_nxt = in_tdata[105:74];
            idx_nxt  = AW'(in_tdata[9:0]);
            if (32'(in_tdata[9:0]) < MAX_SOURCES) begin
              state_nxt = dfv_pkg::ST_LSQ;
            end
          end else begin
            a_nxt = in_tdata[137:106];
            b_nxt = in_tdata[169:138];
            c_nxt = in_tdata[201:170];
            count_nxt = count_in;
            k_nxt  = '0;
            re_nxt = '0;
            im_nxt = '0;
            hz_nxt = 1'b0;
            sat_nxt = 1'b0;
            state_nxt = (count_in == '0) ? dfv_pkg::ST_PDONE : dfv_pkg::ST_PRD;
          end
        end
      end
      // Form r2 = l*l + m*m; at or past the horizon, write a flagged entry
      dfv_pkg::ST_LSQ: begin
        if (cnt_r == 6'd1) begin
          s_nxt = mul_p_r[63:0];
        end else if (cnt_r == 6'd2) begin
          cnt_nxt = '0;
          if (r2_sum >= (64'd1 << 62)) begin
            wr_en = 1'b1;
            wr_entry = '{dir_l: a_r, dir_m: b_r, n_minus_one: '0, weight: '0,
                         beyond_horizon: 1'b1, weight_clipped: 1'b0};
            state_nxt = dfv_pkg::ST_IDLE;
          end else begin
            s_nxt = (64'd1 << 62) - r2_sum;
            root_nxt = '0;
            bit_nxt = 64'd1 << 62;
            state_nxt = dfv_pkg::ST_LSQRT;
          end
        end
      end
      // One root bit per cycle
      dfv_pkg::ST_LSQRT: begin
        if (s_r >= sq_try) begin
          s_nxt = s_r - sq_try;
          root_nxt = (root_r >> 1) + bit_r;
        end else begin
          root_nxt = root_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        if (cnt_r == 6'd31) begin
          cnt_nxt = '0;
          dvd_nxt = {flux_r, 31'd0};
          rem_nxt = '0;
          quo_nxt = '0;
          state_nxt = dfv_pkg::ST_LDIV;
        end
      end
      // One quotient bit per cycle
      dfv_pkg::ST_LDIV: begin
        dvd_nxt = {dvd_r[61:0], 1'b0};
        if (div_t >= root_r[32:0]) begin
          rem_nxt = div_t - root_r[32:0];
          quo_nxt = {quo_r[61:0], 1'b1};
        end else begin
          rem_nxt = div_t;
          quo_nxt = {quo_r[61:0], 1'b0};
        end
        if (cnt_r == 6'd62) begin
          state_nxt = dfv_pkg::ST_LWR;
        end
      end
      dfv_pkg::ST_LWR: begin
        wr_en = 1'b1;
        state_nxt = dfv_pkg::ST_IDLE;
      end
      // Wait for the registered table read
      dfv_pkg::ST_PRD: begin
        cnt_nxt = '0;
        state_nxt = dfv_pkg::ST_PMUL;
      end
      // Skip a source beyond the horizon, else accumulate the phase products
      dfv_pkg::ST_PMUL: begin
        if (cnt_r == 6'd0) begin
          if (rd_entry.beyond_horizon) begin
            hz_nxt = 1'b1;
            k_nxt = k_r + CW'(1);
            state_nxt = last_src ? dfv_pkg::ST_PDONE : dfv_pkg::ST_PRD;
          end else if (rd_entry.weight_clipped) begin
            sat_nxt = 1'b1;
          end
        end else if (cnt_r == 6'd1) begin
          ph_nxt = mul_p_r[42:0];
        end else begin
          ph_nxt = ph_r + mul_p_r[42:0];
          if (cnt_r == 6'd3) begin
            state_nxt = dfv_pkg::ST_PANG;
          end
        end
      end
      // Round the phase and fold it into the CORDIC range
      dfv_pkg::ST_PANG: begin
        cnt_nxt  = '0;
        flip_nxt = angle[31] ^ angle[30];
        z_nxt    = 34'($signed({angle[31] ^ (angle[31] ^ angle[30]), angle[30:0]}));
        x_nxt    = dfv_pkg::CORDIC_GAIN_Q30;
        y_nxt    = '0;
        state_nxt = dfv_pkg::ST_PCOR;
      end
      dfv_pkg::ST_PCOR: begin
        if (!z_r[33]) begin
          x_nxt = x_r - sy;
          y_nxt = y_r + sx;
          z_nxt = z_r - atan_v;
        end else begin
          x_nxt = x_r + sy;
          y_nxt = y_r - sx;
          z_nxt = z_r + atan_v;
        end
        if (cnt_r == 6'(dfv_pkg::CORDIC_STEPS - 1)) begin
          cnt_nxt = '0;
          state_nxt = dfv_pkg::ST_PMC;
        end
      end
      // Weight the cosine and sine, add to the sums
      dfv_pkg::ST_PMC: begin
        if (cnt_r == 6'd1) begin
          re_nxt = acc_res[47:0];
          sat_nxt = sat_r | acc_res[48];
        end else if (cnt_r == 6'd2) begin
          im_nxt = acc_res[47:0];
          sat_nxt = sat_r | acc_res[48];
          k_nxt = k_r + CW'(1);
          state_nxt = last_src ? dfv_pkg::ST_PDONE : dfv_pkg::ST_PRD;
        end
      end
      // Hold until the output register is free
      dfv_pkg::ST_PDONE: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt = {sat_r, hz_r, im_r, re_r};
          out_valid_nxt = 1'b1;
          state_nxt = dfv_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dfv_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dfv_pkg::ST_IDLE;
      cfg_r       <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
    a_r <= a_nxt; b_r <= b_nxt; c_r <= c_nxt; flux_r <= flux_nxt; idx_r <= idx_nxt;
    count_r <= count_nxt; k_r <= k_nxt;
    s_r <= s_nxt; root_r <= root_nxt; bit_r <= bit_nxt;
    rem_r <= rem_nxt; quo_r <= quo_nxt; dvd_r <= dvd_nxt;
    ph_r <= ph_nxt; x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt; flip_r <= flip_nxt;
    re_r <= re_nxt; im_r <= im_nxt; hz_r <= hz_nxt; sat_r <= sat_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_data_r};

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`default_nettype none
module testbench;

  localparam int TABLE_DEPTH = 1024;
  localparam int STALL_LIMIT = 80000;
  localparam int LOAD_SETTLE = 150;
  localparam longint SUM_MAX = 64'sd140737488355327;
  localparam longint SUM_MIN = -64'sd140737488355328;

  // Holds the source table and the expected visibilities
  class visibility_scoreboard;
    typedef struct {
      logic [47:0] re;
      logic [47:0] im;
      logic        hz;
      logic        sat;
    } vis_t;

    bit [31:0] src_l [TABLE_DEPTH];
    bit [31:0] src_m [TABLE_DEPTH];
    bit [31:0] src_nm1 [TABLE_DEPTH];
    bit [31:0] src_wt [TABLE_DEPTH];
    bit        src_hz [TABLE_DEPTH];
    bit        src_clip [TABLE_DEPTH];
    bit [10:0] count_reg;
    vis_t      expected_q[$];
    int        errors;
    int        results;

    function bit [63:0] int_sqrt(bit [63:0] s);
      bit [63:0] r;
      bit [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > s) b = b >> 2;
      while (b != 0) begin
        if (s >= r + b) begin
          s = s - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    // Rotate to the angle (2^-32 turns); cos and sin in Q2.30
    function void rotate(bit [31:0] angle, output longint c, output longint s);
      bit     flip;
      longint x;
      longint y;
      longint z;
      longint nx;
      flip = (angle[31:30] == 2'd1) || (angle[31:30] == 2'd2);
      x = dfv_pkg::CORDIC_GAIN_Q30;
      y = 0;
      z = longint'({32'b0, angle});
      if (flip) z = z - 64'sd2147483648;
      else if (angle[31:30] == 2'd3) z = z - 64'sd4294967296;
      for (int i = 0; i < dfv_pkg::CORDIC_STEPS; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i);
          y = y + (x >>> i);
          z = z - longint'({32'b0, dfv_pkg::ATAN_TURNS[i]});
        end else begin
          nx = x + (y >>> i);
          y = y - (x >>> i);
          z = z + longint'({32'b0, dfv_pkg::ATAN_TURNS[i]});
        end
        x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function longint clamp_add(longint acc, longint t, ref bit sat);
      longint r;
      r = acc + t;
      if (r > SUM_MAX) begin
        sat = 1;
        return SUM_MAX;
      end
      if (r < SUM_MIN) begin
        sat = 1;
        return SUM_MIN;
      end
      return r;
    endfunction

    // Apply one accepted request: store a source or predict a visibility
    function void note_request(logic op, logic [207:0] d);
      bit [9:0]  idx;
      longint    l, m, u, v, w, ph, c, s, wt, re, im;
      bit [31:0] flux;
      bit [63:0] r2, n, q, wq;
      bit        hz, sat;
      int        cnt;
      vis_t      e;
      idx = d[9:0];
      l = $signed(d[41:10]);
      m = $signed(d[73:42]);
      flux = d[105:74];
      u = $signed(d[137:106]);
      v = $signed(d[169:138]);
      w = $signed(d[201:170]);
      if (op == dfv_pkg::OP_LOAD) begin
        src_l[idx] = d[41:10];
        src_m[idx] = d[73:42];
        r2 = l * l + m * m;
        if (r2 >= (64'd1 << 62)) begin
          src_hz[idx] = 1;
          src_nm1[idx] = 0;
          src_wt[idx] = 0;
          src_clip[idx] = 0;
        end else begin
          n = int_sqrt((64'd1 << 62) - r2);
          if (n == 0) n = 1;
          src_hz[idx] = 0;
          src_nm1[idx] = n - (64'd1 << 31);
          wq = ({32'b0, flux} << 31) / n;
          src_clip[idx] = wq > 64'hFFFF_FFFF;
          src_wt[idx] = src_clip[idx] ? 32'hFFFF_FFFF : wq[31:0];
        end
        return;
      end
      cnt = count_reg > TABLE_DEPTH ? TABLE_DEPTH : count_reg;
      re = 0;
      im = 0;
      hz = 0;
      sat = 0;
      for (int k = 0; k < cnt; k++) begin
        if (src_hz[k]) begin
          hz = 1;
          continue;
        end
        if (src_clip[k]) sat = 1;
        ph = u * longint'($signed(src_l[k])) + v * longint'($signed(src_m[k]))
           + w * longint'($signed(src_nm1[k]));
        q = ((ph + (64'd1 << 24)) >> 25) & 64'h3FFFF;
        rotate({q[17:0], 14'b0}, c, s);
        wt = longint'({32'b0, src_wt[k]});
        re = clamp_add(re, (wt * c + (64'sd1 <<< 29)) >>> 30, sat);
        im = clamp_add(im, -((wt * s + (64'sd1 <<< 29)) >>> 30), sat);
      end
      e.re = re[47:0];
      e.im = im[47:0];
      e.hz = hz;
      e.sat = sat;
      expected_q.push_back(e);
    endfunction

    // Compare one delivered visibility with the oldest prediction
    function void check_result(logic [103:0] d);
      vis_t e;
      results++;
      if (expected_q.size() == 0) begin
        errors++;
        $error("unexpected result %h", d);
        return;
      end
      e = expected_q.pop_front();
      if (d[47:0] !== e.re) begin
        errors++;
        $error("sum_real: expected %h actual %h", e.re, d[47:0]);
      end
      if (d[95:48] !== e.im) begin
        errors++;
        $error("sum_imag: expected %h actual %h", e.im, d[95:48]);
      end
      if (d[96] !== e.hz) begin
        errors++;
        $error("horizon_hit: expected %b actual %b", e.hz, d[96]);
      end
      if (d[97] !== e.sat) begin
        errors++;
        $error("saturated: expected %b actual %b", e.sat, d[97]);
      end
    endfunction
  endclass

  logic         clk = 0;
  logic         rst_n = 0;
  logic         cfg_wr_en = 0;
  logic [10:0]  cfg_wr_data = '0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [207:0] in_tdata = '0;
  logic         in_tuser = dfv_pkg::OP_LOAD;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [103:0] out_tdata;

  visibility_scoreboard sb = new;
  bit  loaded [TABLE_DEPTH];
  bit  no_gaps = 0;
  int  idle_cycles = 0;
  int  n_loads = 0;
  int  n_predicts = 0;

  direct_fourier_visibility_predict_top u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Stall the receiver at random, but never while no_gaps is set
  always @(negedge clk) begin
    out_tready <= no_gaps || ($urandom_range(99) >= 34);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > STALL_LIMIT) begin
        $display("timeout after %0d quiet cycles", idle_cycles);
        $display("testbench: errors");
        $finish;
      end
    end
  end

  function int written_prefix();
    for (int i = 0; i < TABLE_DEPTH; i++) if (!loaded[i]) return i;
    return TABLE_DEPTH;
  endfunction

  task automatic send_request(logic op, bit [9:0] idx, bit [31:0] l, bit [31:0] m,
                              bit [31:0] fl, bit [31:0] u, bit [31:0] v, bit [31:0] w);
    if (!no_gaps && $urandom_range(99) < 34) repeat ($urandom_range(1, 6)) @(negedge clk);
    in_tuser = op;
    in_tdata = {6'b0, w, v, u, fl, m, l, idx};
    in_tvalid = 1;
    do @(posedge clk); while (!in_tready);
    sb.note_request(op, in_tdata);
    if (op == dfv_pkg::OP_LOAD) begin
      loaded[idx] = 1;
      n_loads++;
    end else begin
      n_predicts++;
    end
    @(negedge clk);
    in_tvalid = 0;
  endtask

  task automatic random_load(bit [9:0] idx);
    bit [31:0] l, m;
    l = $urandom;
    m = $urandom;
    if ($urandom_range(3) == 0) begin
      l = $signed(l) >>> 2;
      m = $signed(m) >>> 2;
    end
    send_request(dfv_pkg::OP_LOAD, idx, l, m, $urandom >> $urandom_range(0, 31),
                 $urandom, $urandom, $urandom);
  endtask

  task automatic random_predict();
    bit [31:0] u, v, w;
    u = $urandom;
    v = $urandom;
    w = $urandom;
    if ($urandom_range(2) == 0) begin
      u = $signed(u) >>> 12;
      v = $signed(v) >>> 12;
      w = $signed(w) >>> 12;
    end
    send_request(dfv_pkg::OP_PREDICT, 10'($urandom), $urandom, $urandom, $urandom,
                 u, v, w);
  endtask

  // Write the source count once the block has drained
  task automatic set_count(bit [10:0] cnt);
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (LOAD_SETTLE) @(negedge clk);
    cfg_wr_en = 1;
    cfg_wr_data = cnt;
    @(negedge clk);
    sb.count_reg = cnt;
    cfg_wr_en = 0;
  endtask

  initial begin
    int lim;
    repeat (8) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // Empty sum, then the corner sources
    set_count(0);
    send_request(dfv_pkg::OP_PREDICT, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h1234_5678);
    send_request(dfv_pkg::OP_LOAD, 0, 0, 0, 32'h0001_0000, 0, 0, 0);
    send_request(dfv_pkg::OP_LOAD, 1, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 0, 0, 0);
    send_request(dfv_pkg::OP_LOAD, 2, 32'h7FFF_FFFF, 0, 32'hFFFF_FFFF, 0, 0, 0);
    send_request(dfv_pkg::OP_LOAD, 3, 0, 32'h7FFF_FFFF, 32'h0000_0001, 0, 0, 0);
    send_request(dfv_pkg::OP_LOAD, 4, 32'h4000_0000, 32'hC000_0000, 32'h0100_0000, 0, 0, 0);
    send_request(dfv_pkg::OP_LOAD, 5, 32'h8000_0000, 0, 32'h0002_0000, 0, 0, 0);
    send_request(dfv_pkg::OP_LOAD, 6, 32'h0000_0001, 32'hFFFF_FFFF, 0, 0, 0, 0);
    send_request(dfv_pkg::OP_LOAD, 7, 32'h2000_0000, 32'h2000_0000, 32'h0003_8000, 0, 0, 0);
    set_count(8);
    send_request(dfv_pkg::OP_PREDICT, 0, 0, 0, 0, 0, 0, 0);
    send_request(dfv_pkg::OP_PREDICT, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF);
    send_request(dfv_pkg::OP_PREDICT, 0, 0, 0, 0, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000);
    send_request(dfv_pkg::OP_PREDICT, 10'h3FF, '1, '1, '1, 32'h0000_1000, 32'hFFFF_F000,
                 32'h0000_0800);
    random_predict();

    // Random phases over a growing table; one phase runs without gaps
    for (int ph = 0; ph < 10; ph++) begin
      no_gaps = (ph == 4);
      lim = written_prefix();
      set_count(11'($urandom_range(0, lim > 16 ? 16 : lim)));
      repeat (56) begin
        if ($urandom_range(99) < 40) random_load(10'($urandom_range(0, 63)));
        else random_predict();
      end
    end
    no_gaps = 0;

    // Sum the whole loaded prefix of the table
    set_count(11'(written_prefix()));
    random_predict();
    random_predict();

    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    $display("covered %0d source loads and %0d predictions, %0d results checked",
             n_loads, n_predicts, sb.results);
    $display("source counts from zero up to the whole loaded part of the table");
    if (sb.errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
design/dfv_pkg.sv
design/dfv_ram.sv
design/direct_fourier_visibility_predict_top.sv
bench/testbench.sv
